// ----- sv/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon test: register map,
// input mode codes and the control groups between sequencer and edge unit.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Register map (byte address = 4 * index)
  localparam int APB_ADDR_BITS = 4;
  localparam int REG_IDX_BITS  = 2;
  localparam logic [REG_IDX_BITS-1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_POS_X        = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_POS_Y        = 2'd2;

  // Input item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Smallest vertex count that forms a polygon
  localparam int MIN_VERTICES = 3;

  // Tag that travels with each vertex read through the edge pipeline
  typedef struct packed {
    logic valid;  // vertex data present
    logic first;  // opening vertex of the walk, no edge ends here
    logic last;   // closing vertex of the walk
  } edge_ctl_t;

  // Verdict of one full walk
  typedef struct packed {
    logic done;
    logic in_poly;
    logic boundary;
  } edge_res_t;

endpackage

// ----- sv/pip_ram.sv -----
// ----------------------------------------------------------------------------
// pip_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/pip_edge.sv -----
// ----------------------------------------------------------------------------
// pip_edge
// Edge pipeline: places each vertex read from the store, forms the edge from
// the previous vertex, runs the exact on-edge and ray-crossing tests and
// accumulates the boundary flag and the even-odd parity over the walk.
// ----------------------------------------------------------------------------
module pip_edge
  import pip_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  edge_ctl_t                    ctl,
  input  logic signed [COORD_BITS-1:0] rd_x,
  input  logic signed [COORD_BITS-1:0] rd_y,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic signed [COORD_BITS-1:0] pt_x,
  input  logic signed [COORD_BITS-1:0] pt_y,
  output edge_res_t                    res
);

  localparam int AB = COORD_BITS + 1;  // absolute vertex
  localparam int DB = COORD_BITS + 2;  // differences
  localparam int PB = 2 * DB;          // products
  localparam int SB = PB + 1;          // sums of products

  edge_ctl_t ctl_a, ctl_b, ctl_c;

  logic signed [AB-1:0] a_x, a_y, b_x, b_y;
  logic signed [DB-1:0] ex, ey, qx, qy;
  logic                 cond_b, dpos_b, cond_c, dpos_c;
  logic signed [PB-1:0] p_eq, p_ye, p_qe, p_qy, p_xx, p_yy;
  logic signed [SB-1:0] dot, len2;
  logic                 on_edge, hit;
  logic                 b_acc, par;

  // Tag pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
      ctl_b <= '0;
      ctl_c <= '0;
    end else begin
      ctl_a <= ctl;
      ctl_b <= ctl_a;
      ctl_c <= ctl_b;
    end
  end

  // Place the vertex and shift the previous one into the edge start
  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      b_x <= AB'(rd_x) + AB'(pos_x);
      b_y <= AB'(rd_y) + AB'(pos_y);
      a_x <= b_x;
      a_y <= b_y;
    end
  end

  // Edge and point differences, crossing condition
  always_ff @(posedge clk) begin
    ex     <= DB'(b_x) - DB'(a_x);
    ey     <= DB'(b_y) - DB'(a_y);
    qx     <= DB'(pt_x) - DB'(a_x);
    qy     <= DB'(pt_y) - DB'(a_y);
    cond_b <= (a_y > AB'(pt_y)) != (b_y > AB'(pt_y));
    dpos_b <= b_y > a_y;
  end

  // Products: cross terms double as the ray comparison sides
  always_ff @(posedge clk) begin
    p_eq   <= ex * qy;
    p_ye   <= ey * qx;
    p_qe   <= qx * ex;
    p_qy   <= qy * ey;
    p_xx   <= ex * ex;
    p_yy   <= ey * ey;
    cond_c <= cond_b;
    dpos_c <= dpos_b;
  end

  // On-edge and crossing decisions
  always_comb begin
    dot     = SB'(p_qe) + SB'(p_qy);
    len2    = SB'(p_xx) + SB'(p_yy);
    on_edge = (p_eq == p_ye) && !dot[SB-1] && (dot <= len2);
    hit     = cond_c && (dpos_c ? (p_ye < p_eq) : (p_ye > p_eq));
  end

  // Accumulate over the walk and report on the closing edge
  always_ff @(posedge clk) begin
    if (rst) begin
      b_acc <= 1'b0;
      par   <= 1'b0;
      res   <= '0;
    end else begin
      res.done <= ctl_c.valid & ctl_c.last;
      if (ctl_c.valid) begin
        if (ctl_c.first) begin
          b_acc <= 1'b0;
          par   <= 1'b0;
        end else begin
          b_acc <= b_acc | on_edge;
          par   <= par ^ hit;
        end
        if (ctl_c.last) begin
          res.boundary <= b_acc | on_edge;
          res.in_poly  <= b_acc | on_edge | (par ^ hit);
        end
      end
    end
  end

endmodule

// ----- sv/point_in_polygon_test.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd point-in-polygon test with exact boundary detection. Vertex
// offsets sit in a RAM; a query walks every edge through a pipelined unit.
//
//   Channel  Signals                                  Direction
//   input    in_valid/in_ready, mode, vertex_index,   in
//            coord_x, coord_y
//   result   out_valid/out_ready, inside_res,         out
//            on_boundary
//   config   psel/penable/pwrite/paddr/pwdata,        in / out
//            prdata/pready
//
// A load writes its vertex into the RAM when taken. A query over n >= 3
// vertices makes n + 1 RAM reads, one per cycle; the next item can be taken
// once its result shows. Fewer than 3 vertices: no walk, result outside.
// Reset clears control state only; the vertex RAM is not cleared.
// A waiting result sits in the output register while the next item is taken;
// a following query result holds the sequencer until that register frees.
// ----------------------------------------------------------------------------
module point_in_polygon_test
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic [5:0]                   vertex_index,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         inside_res,
  output logic                         on_boundary,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_BITS-1:0]     paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_FINISH} state_t;

  state_t state;

  logic [6:0]                   vertex_count;
  logic signed [COORD_BITS-1:0] pos_x, pos_y;
  logic signed [COORD_BITS-1:0] pt_x, pt_y;
  logic [CW-1:0]                vert_n, walk_cnt, n_sat, n_m1, wk_m1;
  logic                         res_inside, res_bound;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [2*COORD_BITS-1:0] ram_wdata, ram_rdata;

  edge_ctl_t issue_ctl;
  edge_res_t edge_res;

  logic                    in_xfer, cfg_wr, idx_ok;
  logic [REG_IDX_BITS-1:0] reg_idx;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_BITS-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      pos_x        <= '0;
      pos_y        <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_VERTEX_COUNT: vertex_count <= pwdata[6:0];
        REG_POS_X:        pos_x        <= pwdata[COORD_BITS-1:0];
        REG_POS_Y:        pos_y        <= pwdata[COORD_BITS-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_VERTEX_COUNT: prdata = 32'(vertex_count);
      REG_POS_X:        prdata = {{(32-COORD_BITS){1'b0}}, pos_x};
      REG_POS_Y:        prdata = {{(32-COORD_BITS){1'b0}}, pos_y};
      default:          prdata = '0;
    endcase
  end

  // Input side and vertex store access
  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid & in_ready;
  assign idx_ok   = 32'(vertex_index) < MAX_VERTICES;

  always_comb begin
    n_sat = (32'(vertex_count) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vertex_count);
    n_m1  = vert_n - CW'(1);
    wk_m1 = walk_cnt - CW'(1);
  end

  assign ram_we    = in_xfer && (mode == MODE_LOAD) && idx_ok;
  assign ram_waddr = AW'(vertex_index);
  assign ram_wdata = {coord_x, coord_y};
  assign ram_re    = (state == S_WALK);
  // Walk opens at the last vertex, then runs 0 .. n-1
  assign ram_raddr = (walk_cnt == '0) ? n_m1[AW-1:0] : wk_m1[AW-1:0];

  pip_ram #(
    .WIDTH(2 * COORD_BITS),
    .DEPTH(MAX_VERTICES)
  ) u_vtx_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Tag each read so it lines up with the RAM data
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_ctl <= '0;
    end else begin
      issue_ctl.valid <= (state == S_WALK);
      issue_ctl.first <= (walk_cnt == '0);
      issue_ctl.last  <= (walk_cnt == vert_n);
    end
  end

  pip_edge #(
    .COORD_BITS(COORD_BITS)
  ) u_edge (
    .clk  (clk),
    .rst  (rst),
    .ctl  (issue_ctl),
    .rd_x (ram_rdata[2*COORD_BITS-1:COORD_BITS]),
    .rd_y (ram_rdata[COORD_BITS-1:0]),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pt_x (pt_x),
    .pt_y (pt_y),
    .res  (edge_res)
  );

  // Query sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      walk_cnt  <= '0;
    end else begin
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer && (mode == MODE_QUERY)) begin
            pt_x     <= coord_x;
            pt_y     <= coord_y;
            vert_n   <= n_sat;
            walk_cnt <= '0;
            if (n_sat < CW'(MIN_VERTICES)) begin
              res_inside <= 1'b0;
              res_bound  <= 1'b0;
              state      <= S_FINISH;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          walk_cnt <= walk_cnt + CW'(1);
          if (walk_cnt == vert_n) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (edge_res.done) begin
            res_inside <= edge_res.in_poly;
            res_bound  <= edge_res.boundary;
            state      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            inside_res  <= res_inside;
            on_boundary <= res_bound;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
